@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, live through reset
`define ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tdh_pkg.sv @@
// ----------------------------------------------------------------------------
// tdh_pkg
// Widths, constants and the month table of the timestamp difference block.
// ----------------------------------------------------------------------------
package tdh_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int TS_W    = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W;
  localparam int IN_W    = 2 * TS_W;
  localparam int HOURS_W = 27;
  localparam int OUT_W   = 40;

  localparam int DAYS_W  = 23;
  localparam int TOTH_W  = 28;
  localparam int SOH_W   = 12;

  localparam int SECS_PER_HOUR = 3600;
  localparam int RECIP25    = 5243;
  localparam int RECIP25_SH = 17;
  localparam int RECIP15    = 4370;
  localparam int RECIP15_SH = 16;

  localparam int HOURS_LSB = 0;
  localparam int MINS_LSB  = HOURS_W;
  localparam int SECS_LSB  = HOURS_W + MIN_W;

  // days in the full months before the given month, common year
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
    logic [8:0] d;
    unique case (month)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      default:    d = 9'd334;
    endcase
    if (month > 4'd12) begin
      d = 9'd365;
    end
    return d;
  endfunction

endpackage

@@ rtl/timestamp_difference_hms.sv @@
// Throughput: one item per cycle while the output is not stalled, set by six register
// stages with a ready chain that lets stalled stages fill bubbles.
// Reset (rst, synchronous, active high) clears every stage valid; payload is not reset.
// ----------------------------------------------------------------------------
// timestamp_difference_hms
// Absolute difference of two calendar date-times, split into h, min and s.
// ----------------------------------------------------------------------------
module timestamp_difference_hms (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // first_year, first_month, first_day, first_hour, first_minute, first_second,
  // second_year, second_month, second_day, second_hour, second_minute, second_sec
  input  logic [tdh_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // diff_hours, diff_minutes, diff_seconds, zero pad
  output logic [tdh_pkg::OUT_W-1:0] m_tdata
);
  import tdh_pkg::*;

  localparam int NSTG = 6;

  typedef struct packed {
    logic [DAYS_W-1:0] y365;
    logic [11:0]       n4;
    logic [7:0]        q100;
    logic [5:0]        q400;
    logic              ynz;
    logic [11:0]       y4;
    logic [1:0]        ylo2;
    logic [7:0]        yq4;
    logic [5:0]        yq16;
    logic [8:0]        dbm;
    logic              late;
    logic [DAY_W-1:0]  dadd;
    logic [HOUR_W-1:0] hour;
    logic [SOH_W-1:0]  ms;
  } st1_t;

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [5:0]        hr;
    logic [SOH_W-1:0]  soh;
  } st2_t;

  typedef struct packed {
    logic [TOTH_W-1:0] toth;
    logic [SOH_W-1:0]  soh;
  } st3_t;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;

  st1_t st1 [2];
  st2_t st2 [2];
  st3_t st3 [2];
  st1_t st1_next [2];
  st2_t st2_next [2];
  st3_t st3_next [2];

  logic [TOTH_W-1:0] dh4, dh5, dh6;
  logic [SOH_W-1:0]  ds4, ds5, ds6;
  logic [5:0]        q5, q6;
  logic [TOTH_W-1:0] dh_next;
  logic [SOH_W-1:0]  ds_next;
  logic [5:0]        q_next;

  // ready chain
  always_comb begin
    rdy[NSTG] = m_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: products and field decode
  always_comb begin
    logic [TS_W-1:0]    ts;
    logic [YEAR_W-1:0]  year;
    logic [YEAR_W-1:0]  n;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   sec;
    logic [24:0]        p100;
    logic [22:0]        p400;
    logic [24:0]        py4;
    logic [22:0]        py16;
    for (int t = 0; t < 2; t++) begin
      ts     = s_tdata[t*TS_W +: TS_W];
      year   = ts[YEAR_W-1:0];
      month  = ts[YEAR_W +: MONTH_W];
      day    = ts[YEAR_W+MONTH_W +: DAY_W];
      minute = ts[YEAR_W+MONTH_W+DAY_W+HOUR_W +: MIN_W];
      sec    = ts[YEAR_W+MONTH_W+DAY_W+HOUR_W+MIN_W +: SEC_W];
      n      = year - YEAR_W'(1);
      p100   = 25'(n[13:2]) * 25'(RECIP25);
      p400   = 23'(n[13:4]) * 23'(RECIP25);
      py4    = 25'(year[13:2]) * 25'(RECIP25);
      py16   = 23'(year[13:4]) * 23'(RECIP25);
      st1_next[t].y365 = DAYS_W'(year) * DAYS_W'(365);
      st1_next[t].n4   = n[13:2];
      st1_next[t].q100 = p100[RECIP25_SH +: 8];
      st1_next[t].q400 = p400[RECIP25_SH +: 6];
      st1_next[t].ynz  = (year != '0);
      st1_next[t].y4   = year[13:2];
      st1_next[t].ylo2 = year[1:0];
      st1_next[t].yq4  = py4[RECIP25_SH +: 8];
      st1_next[t].yq16 = py16[RECIP25_SH +: 6];
      st1_next[t].dbm  = days_before(month);
      st1_next[t].late = (month > MONTH_W'(2));
      st1_next[t].dadd = (day != '0) ? day - DAY_W'(1) : '0;
      st1_next[t].hour = ts[YEAR_W+MONTH_W+DAY_W +: HOUR_W];
      st1_next[t].ms   = SOH_W'(minute) * SOH_W'(60) + SOH_W'(sec);
    end
  end

  // stage 2: day count, leap test, seconds-in-hour normalise
  always_comb begin
    logic [11:0] lcnt;
    logic        y100;
    logic        y400;
    logic        leap;
    logic        hc;
    for (int t = 0; t < 2; t++) begin
      lcnt = st1[t].ynz ? st1[t].n4 - 12'(st1[t].q100) + 12'(st1[t].q400) : '0;
      y100 = (12'(st1[t].yq4) * 12'd25 == st1[t].y4);
      y400 = (10'(st1[t].yq16) * 10'd25 == st1[t].y4[11:2]) &&
             (st1[t].y4[1:0] == 2'd0) && (st1[t].ylo2 == 2'd0);
      leap = ((st1[t].ylo2 == 2'd0) && !y100) || y400;
      hc   = (st1[t].ms >= SOH_W'(SECS_PER_HOUR));
      st2_next[t].days = st1[t].y365 + DAYS_W'(lcnt) + DAYS_W'(st1[t].dbm) +
                         DAYS_W'(st1[t].late && leap) + DAYS_W'(st1[t].dadd);
      st2_next[t].hr   = 6'(st1[t].hour) + 6'(hc);
      st2_next[t].soh  = hc ? st1[t].ms - SOH_W'(SECS_PER_HOUR) : st1[t].ms;
    end
  end

  // stage 3: total hours
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      st3_next[t].toth = (TOTH_W'(st2[t].days) << 4) + (TOTH_W'(st2[t].days) << 3) +
                         TOTH_W'(st2[t].hr);
      st3_next[t].soh  = st2[t].soh;
    end
  end

  // stage 4: ordered subtract with borrow between hours and seconds
  always_comb begin
    logic              a_gt;
    logic              borrow;
    logic [TOTH_W-1:0] hl, hs;
    logic [SOH_W-1:0]  sl, ss;
    a_gt = (st3[0].toth > st3[1].toth) ||
           ((st3[0].toth == st3[1].toth) && (st3[0].soh > st3[1].soh));
    hl = a_gt ? st3[0].toth : st3[1].toth;
    hs = a_gt ? st3[1].toth : st3[0].toth;
    sl = a_gt ? st3[0].soh  : st3[1].soh;
    ss = a_gt ? st3[1].soh  : st3[0].soh;
    borrow  = (sl < ss);
    ds_next = borrow ? sl - ss + SOH_W'(SECS_PER_HOUR) : sl - ss;
    dh_next = hl - hs - TOTH_W'(borrow);
  end

  // stage 5: minutes by reciprocal of 60
  always_comb begin
    logic [22:0] pq;
    pq     = 23'(ds4[11:2]) * 23'(RECIP15);
    q_next = pq[RECIP15_SH +: 6];
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && s_tvalid) begin
      st1 <= st1_next;
    end
    if (rdy[1] && vld[0]) begin
      st2 <= st2_next;
    end
    if (rdy[2] && vld[1]) begin
      st3 <= st3_next;
    end
    if (rdy[3] && vld[2]) begin
      dh4 <= dh_next;
      ds4 <= ds_next;
    end
    if (rdy[4] && vld[3]) begin
      dh5 <= dh4;
      ds5 <= ds4;
      q5  <= q_next;
    end
    if (rdy[5] && vld[4]) begin
      dh6 <= dh5;
      ds6 <= ds5 - (SOH_W'(q5) << 6) + (SOH_W'(q5) << 2);
      q6  <= q5;
    end
  end

  assign m_tdata = {1'b0, ds6[SEC_W-1:0], q6, dh6[HOURS_W-1:0]};

endmodule

@@ rtl/tdh_checker.sv @@
// ----------------------------------------------------------------------------
// tdh_checker
// Port-level checks on the timestamp difference block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdh_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [tdh_pkg::OUT_W-1:0] m_tdata
);
  import tdh_pkg::*;

  logic [MIN_W-1:0] mins;
  logic [SEC_W-1:0] secs;

  assign mins = m_tdata[MINS_LSB +: MIN_W];
  assign secs = m_tdata[SECS_LSB +: SEC_W];

  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled output item changed")
  `ASSERT_CLK(a_hms_range, clk, rst, m_tvalid |-> (mins < 6'd60) && (secs < 6'd60), "minutes or seconds out of range")
  `ASSERT_CLK(a_stall_only_full, clk, rst, !s_tready |-> m_tvalid && !m_tready, "input stalled with room in pipeline")
  `ASSERT_RST(a_reset_empty, clk, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind timestamp_difference_hms tdh_checker u_tdh_checker (.*);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for timestamp_difference_hms. A short table of directed
// date pairs (leap rules, out-of-range months, days and times, field extremes)
// is followed by random pairs, mostly valid dates with some raw bit patterns.
// Every accepted item is scored against a typed result or a local calendar
// model. The sender idles in bursts; the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import tdh_pkg::*;

  typedef struct packed {
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } stamp_t;

  typedef struct packed {
    logic [OUT_W-HOURS_W-MIN_W-SEC_W-1:0] pad;
    logic [SEC_W-1:0]                      secs;
    logic [MIN_W-1:0]                      mins;
    logic [HOURS_W-1:0]                    hours;
  } result_t;

  typedef struct packed {
    stamp_t  a;
    stamp_t  b;
    logic    typed;
    result_t want;
  } vector_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  localparam logic    TYPED     = 1'b1;
  localparam logic    PREDICTED = 1'b0;
  localparam result_t NO_HMS    = '0;
  localparam int      N_RANDOM  = 450;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  logic              typed_now = 1'b0;
  result_t           typed_want = '0;
  result_t           hms_due[$];
  vector_t           vectors[$];
  int                mismatches = 0;
  int                burst_left = 0;
  rx_mode_t          rx_mode = RX_OPEN;
  logic [7:0]        rx_count = '0;

  timestamp_difference_hms uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic stamp_t stamp(input int y, input int mo, input int d,
                                   input int h, input int mi, input int s);
    stamp_t t;
    t.year   = y[YEAR_W-1:0];
    t.month  = mo[MONTH_W-1:0];
    t.day    = d[DAY_W-1:0];
    t.hour   = h[HOUR_W-1:0];
    t.minute = mi[MIN_W-1:0];
    t.second = s[SEC_W-1:0];
    return t;
  endfunction

  function automatic result_t hms(input int h, input int m, input int s);
    result_t r;
    r       = '0;
    r.hours = h[HOURS_W-1:0];
    r.mins  = m[MIN_W-1:0];
    r.secs  = s[SEC_W-1:0];
    return r;
  endfunction

  function automatic logic [63:0] stamp_seconds(input stamp_t t);
    logic [63:0] yr;
    logic [63:0] n;
    logic [63:0] days;
    logic        leap;
    yr   = 64'(t.year);
    days = yr * 365;
    if (yr >= 1) begin
      n    = yr - 1;
      days = days + n / 4 - n / 100 + n / 400;
    end
    case (t.month)
      4'd2:  days = days + 31;
      4'd3:  days = days + 59;
      4'd4:  days = days + 90;
      4'd5:  days = days + 120;
      4'd6:  days = days + 151;
      4'd7:  days = days + 181;
      4'd8:  days = days + 212;
      4'd9:  days = days + 243;
      4'd10: days = days + 273;
      4'd11: days = days + 304;
      4'd12: days = days + 334;
      4'd13, 4'd14, 4'd15: days = days + 365;
      default: days = days;
    endcase
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    if (t.month > 2 && leap) begin
      days = days + 1;
    end
    if (t.day >= 1) begin
      days = days + 64'(t.day) - 1;
    end
    return days * 86400 + 64'(t.hour) * 3600 + 64'(t.minute) * 60 + 64'(t.second);
  endfunction

  function automatic result_t span_hms(input stamp_t a, input stamp_t b);
    logic [63:0] sa;
    logic [63:0] sb;
    logic [63:0] d;
    logic [63:0] rem;
    logic [63:0] whole;
    result_t     r;
    sa      = stamp_seconds(a);
    sb      = stamp_seconds(b);
    d       = (sb > sa) ? sb - sa : sa - sb;
    rem     = d % 3600;
    whole   = d / 3600;
    r       = '0;
    r.hours = whole[HOURS_W-1:0];
    r.mins  = MIN_W'(rem / 60);
    r.secs  = SEC_W'(rem % 60);
    return r;
  endfunction

  function automatic stamp_t any_date();
    stamp_t t;
    t.year   = YEAR_W'($urandom_range(1, 9999));
    t.month  = MONTH_W'($urandom_range(1, 12));
    t.day    = DAY_W'($urandom_range(1, 28));
    if ($urandom_range(0, 3) == 0) begin
      t.day = DAY_W'($urandom_range(29, 31));
    end
    t.hour   = HOUR_W'($urandom_range(0, 23));
    t.minute = MIN_W'($urandom_range(0, 59));
    t.second = SEC_W'($urandom_range(0, 59));
    return t;
  endfunction

  // end of February / start of March around century and leap years
  function automatic stamp_t near_leap();
    stamp_t t;
    int     base;
    t = any_date();
    case ($urandom_range(0, 5))
      0: base = 1600;
      1: base = 1700;
      2: base = 1900;
      3: base = 2000;
      4: base = 2100;
      default: base = 2400;
    endcase
    t.year  = YEAR_W'(base + $urandom_range(0, 8) - 4);
    t.month = MONTH_W'($urandom_range(2, 3));
    t.day   = (t.month == 2) ? DAY_W'($urandom_range(28, 29)) : DAY_W'(1);
    return t;
  endfunction

  task automatic send_pair(input stamp_t a, input stamp_t b, input logic typed,
                           input result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left = burst_left - 1;
    s_tdata    <= {b, a};
    s_tvalid   <= 1'b1;
    typed_now  <= typed;
    typed_want <= want;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    rx_count <= rx_count + 1'b1;
    if (rx_count == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= (rx_count[1:0] == 2'd0);
      default:   m_tready <= (rx_count[4:0] >= 5'd12);
    endcase
  end

  always @(posedge clk) begin : scoreboard
    result_t got;
    result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (hms_due.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("unexpected result %0d:%0d:%0d", got.hours, got.mins, got.secs);
          end
        end else begin
          want = hms_due.pop_front();
          if (got.hours !== want.hours || got.mins !== want.mins ||
              got.secs !== want.secs) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("mismatch: expected %0d:%0d:%0d got %0d:%0d:%0d",
                       want.hours, want.mins, want.secs,
                       got.hours, got.mins, got.secs);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        hms_due.push_back(typed_now ? typed_want :
                          span_hms(s_tdata[TS_W-1:0], s_tdata[IN_W-1:TS_W]));
      end
    end
  end

  initial begin : stimulus
    int       i;
    int       pick;
    stamp_t   a;
    stamp_t   b;
    vector_t  v;
    logic [95:0] raw;

    // identical stamps, one second either way, just under an hour, one day across year and month ends
    vectors.push_back({stamp(2000, 1, 1, 0, 0, 0), stamp(2000, 1, 1, 0, 0, 0),
                       TYPED, hms(0, 0, 0)});
    vectors.push_back({stamp(2000, 1, 1, 0, 0, 0), stamp(2000, 1, 1, 0, 0, 1),
                       TYPED, hms(0, 0, 1)});
    vectors.push_back({stamp(2000, 1, 1, 0, 0, 1), stamp(2000, 1, 1, 0, 0, 0),
                       TYPED, hms(0, 0, 1)});
    vectors.push_back({stamp(2000, 6, 15, 12, 0, 0), stamp(2000, 6, 15, 12, 59, 59),
                       TYPED, hms(0, 59, 59)});
    vectors.push_back({stamp(1999, 12, 31, 0, 0, 0), stamp(2000, 1, 1, 0, 0, 0),
                       TYPED, hms(24, 0, 0)});
    vectors.push_back({stamp(2023, 7, 31, 0, 0, 0), stamp(2023, 8, 1, 0, 0, 0),
                       TYPED, hms(24, 0, 0)});
    // leap rules: by 4, not by 100, by 400, and year zero
    vectors.push_back({stamp(2004, 2, 28, 0, 0, 0), stamp(2004, 3, 1, 0, 0, 0),
                       TYPED, hms(48, 0, 0)});
    vectors.push_back({stamp(1900, 2, 28, 0, 0, 0), stamp(1900, 3, 1, 0, 0, 0),
                       TYPED, hms(24, 0, 0)});
    vectors.push_back({stamp(2100, 2, 28, 0, 0, 0), stamp(2100, 3, 1, 0, 0, 0),
                       TYPED, hms(24, 0, 0)});
    vectors.push_back({stamp(2000, 2, 28, 0, 0, 0), stamp(2000, 3, 1, 0, 0, 0),
                       TYPED, hms(48, 0, 0)});
    vectors.push_back({stamp(2400, 2, 28, 0, 0, 0), stamp(2400, 3, 1, 0, 0, 0),
                       TYPED, hms(48, 0, 0)});
    vectors.push_back({stamp(0, 2, 28, 0, 0, 0), stamp(0, 3, 1, 0, 0, 0),
                       TYPED, hms(48, 0, 0)});
    vectors.push_back({stamp(0, 1, 1, 0, 0, 0), stamp(1, 1, 1, 0, 0, 0),
                       PREDICTED, NO_HMS});
    // month zero, months past December, day zero, day past month end, out-of-range time fields
    vectors.push_back({stamp(2023, 0, 10, 0, 0, 0), stamp(2023, 1, 10, 0, 0, 0),
                       TYPED, hms(0, 0, 0)});
    vectors.push_back({stamp(2023, 13, 1, 0, 0, 0), stamp(2023, 15, 1, 0, 0, 0),
                       TYPED, hms(0, 0, 0)});
    vectors.push_back({stamp(2024, 14, 1, 0, 0, 0), stamp(2024, 12, 31, 0, 0, 0),
                       PREDICTED, NO_HMS});
    vectors.push_back({stamp(2001, 13, 1, 0, 0, 0), stamp(2002, 1, 1, 0, 0, 0),
                       PREDICTED, NO_HMS});
    vectors.push_back({stamp(2023, 5, 0, 0, 0, 0), stamp(2023, 5, 1, 0, 0, 0),
                       TYPED, hms(0, 0, 0)});
    vectors.push_back({stamp(2023, 2, 31, 0, 0, 0), stamp(2023, 3, 3, 0, 0, 0),
                       TYPED, hms(0, 0, 0)});
    vectors.push_back({stamp(2023, 5, 5, 0, 0, 0), stamp(2023, 5, 5, 31, 63, 63),
                       PREDICTED, NO_HMS});
    // field extremes, including hour wrap beyond year 9999
    vectors.push_back({stamp(1, 1, 1, 0, 0, 0), stamp(9999, 12, 31, 23, 59, 59),
                       PREDICTED, NO_HMS});
    vectors.push_back({stamp(0, 0, 0, 0, 0, 0), stamp(16383, 15, 31, 31, 63, 63),
                       PREDICTED, NO_HMS});
    vectors.push_back({stamp(16383, 12, 31, 23, 59, 59), stamp(1, 1, 1, 0, 0, 0),
                       PREDICTED, NO_HMS});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (vectors[k]) begin
      v = vectors[k];
      send_pair(v.a, v.b, v.typed, v.want);
    end

    for (i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        raw = {$urandom, $urandom, $urandom};
        a   = raw[TS_W-1:0];
        b   = raw[IN_W-1:TS_W];
      end else if (pick < 35) begin
        a = near_leap();
        b = near_leap();
        if ($urandom_range(0, 1) == 0) begin
          b.year = a.year;
        end
      end else begin
        a = any_date();
        if (pick < 65) begin
          b = any_date();
        end else begin
          b = a;
          if ($urandom_range(0, 2) == 0) b.second = SEC_W'($urandom_range(0, 59));
          if ($urandom_range(0, 2) == 0) b.minute = MIN_W'($urandom_range(0, 59));
          if ($urandom_range(0, 2) == 0) b.hour   = HOUR_W'($urandom_range(0, 23));
          if ($urandom_range(0, 2) == 0) b.day    = DAY_W'($urandom_range(1, 31));
          if ($urandom_range(0, 3) == 0) b.year   = a.year + 1'b1;
        end
      end
      send_pair(a, b, PREDICTED, NO_HMS);
    end

    s_tvalid <= 1'b0;
    while (hms_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && hms_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
